/* rtl/signed_int_to_decimal_ascii_defines.svh */
// Assertion macros for the decimal text converter RTL, used by sida_back.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SIDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sida check failed");

// Next-cycle implication, checked outside reset.
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sida check failed");

`endif

/* rtl/sida_pkg.sv */
// Shared types, constants and helpers for the decimal text converter.
package sida_pkg;

  // Default input width
  localparam int VALUE_BITS_DEF = 32;
  // Entries in the queue between converter and emitter
  localparam int Q_DEPTH_DEF = 2;
  // Magnitude bits folded into the BCD register per cycle
  localparam int BITS_PER_STEP = 2;

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  // Decimal digits of the largest unsigned value of the given width:
  // floor(bits * log10(2)) + 1, with log10(2) ~ 1233 / 4096.
  function automatic int digits_for(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_SIGN,
    BE_DIGIT
  } be_state_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/sida_front.sv */
// Front end: takes a value, forms sign and magnitude, converts to BCD by shift-add-3.
module sida_front
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [VALUE_BITS-1:0]              in_value,
  input  q_stat_t                                   q_stat,
  output logic                                      push,
  output logic [digits_for(VALUE_BITS)*4:0]         push_data
);

  localparam int MAG_W  = VALUE_BITS + (VALUE_BITS % 2);
  localparam int STEPS  = MAG_W / BITS_PER_STEP;
  localparam int CNT_W  = $clog2(STEPS + 1);
  localparam int ND     = digits_for(VALUE_BITS);
  localparam int BCD_W  = ND * 4;

  fe_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic               neg_r, neg_nxt;

  logic [VALUE_BITS-1:0] raw_u;
  logic [VALUE_BITS-1:0] abs_u;
  logic [MAG_W-1:0]      mag_step;
  logic [BCD_W-1:0]      bcd_step;

  // Magnitude is VALUE_BITS wide unsigned, so the most negative value fits
  assign raw_u = $unsigned(in_value);
  assign abs_u = raw_u[VALUE_BITS-1] ? (~raw_u + 1'b1) : raw_u;

  // Two shift-add-3 steps per cycle
  always_comb begin
    mag_step = mag_r;
    bcd_step = bcd_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < ND; d++) begin
        if (bcd_step[d*4 +: 4] >= 4'd5) begin
          bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BCD_W-2:0], mag_step[MAG_W-1]};
      mag_step = {mag_step[MAG_W-2:0], 1'b0};
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    push      = 1'b0;
    busy      = (state_r != FE_IDLE);
    case (state_r)
      FE_IDLE: begin
        if (start) begin
          neg_nxt   = raw_u[VALUE_BITS-1];
          mag_nxt   = MAG_W'(abs_u);
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(STEPS);
          state_nxt = FE_CONV;
        end
      end
      FE_CONV: begin
        mag_nxt = mag_step;
        bcd_nxt = bcd_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = FE_PUSH;
        end
      end
      FE_PUSH: begin
        // Hold the converted beat until the queue has room
        if (!q_stat.full) begin
          push      = 1'b1;
          state_nxt = FE_IDLE;
        end
      end
      default: begin
        state_nxt = FE_IDLE;
      end
    endcase
  end

  assign push_data = {neg_r, bcd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

endmodule

/* rtl/sida_queue.sv */
// Small register queue between the converter and the character emitter.
module sida_queue
  import sida_pkg::*;
#(
  parameter int WIDTH = 41,
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/sida_back.sv */
// Back end: pops BCD words and emits sign and digits, one character per cycle within a word.
`include "signed_int_to_decimal_ascii_defines.svh"

module sida_back
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  q_stat_t                            q_stat,
  input  logic [digits_for(VALUE_BITS)*4:0]  pop_data,
  output logic                               pop,
  output logic                               out_strobe,
  output logic [6:0]                         out_char_code,
  output logic                               out_is_last
);

  localparam int ND    = digits_for(VALUE_BITS);
  localparam int BCD_W = ND * 4;
  localparam int IDX_W = $clog2(ND);

  be_state_t         state_r, state_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              strobe_r, strobe_nxt;
  logic [6:0]        char_r, char_nxt;
  logic              last_r, last_nxt;
  logic [IDX_W-1:0]  msd_idx;
  logic [3:0]        digit;

  // Highest nonzero digit of the incoming word; zero maps to the units digit
  always_comb begin
    msd_idx = '0;
    for (int i = 0; i < ND; i++) begin
      if (pop_data[i*4 +: 4] != 4'd0) begin
        msd_idx = IDX_W'(i);
      end
    end
  end

  assign digit = bcd_r[idx_r*4 +: 4];

  // Next state and output beat
  always_comb begin
    state_nxt  = state_r;
    bcd_nxt    = bcd_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;
    pop        = 1'b0;
    case (state_r)
      BE_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          bcd_nxt   = pop_data[BCD_W-1:0];
          idx_nxt   = msd_idx;
          state_nxt = pop_data[BCD_W] ? BE_SIGN : BE_DIGIT;
        end
      end
      BE_SIGN: begin
        strobe_nxt = 1'b1;
        char_nxt   = CHAR_MINUS;
        last_nxt   = 1'b0;
        state_nxt  = BE_DIGIT;
      end
      BE_DIGIT: begin
        strobe_nxt = 1'b1;
        char_nxt   = CHAR_ZERO + 7'(digit);
        last_nxt   = (idx_r == '0);
        if (idx_r == '0) begin
          state_nxt = BE_IDLE;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      default: begin
        state_nxt = BE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BE_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r  <= bcd_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_char_code = char_r;
  assign out_is_last   = last_r;

  // Checks
  `SIDA_ASSERT_NOW(a_digit_range, clk, rst_n,
    strobe_r && (char_r != CHAR_MINUS),
    (char_r >= CHAR_ZERO) && (char_r <= CHAR_ZERO + 7'd9))
  `SIDA_ASSERT_NOW(a_sign_not_last, clk, rst_n,
    strobe_r && (char_r == CHAR_MINUS), !last_r)
  `SIDA_ASSERT_NEXT(a_sign_then_digit, clk, rst_n,
    strobe_r && (char_r == CHAR_MINUS), strobe_r && (char_r != CHAR_MINUS))
  `SIDA_ASSERT_NOW(a_pop_nonempty, clk, rst_n, pop, !q_stat.empty)

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Top level: signed integer to decimal ASCII text, one character per beat.
//
//   channel   direction  handshake            payload
//   input     in         start / busy         in_value
//   result    out        out_strobe (1 cycle) out_char_code, out_is_last
//
// busy is high from an accepted beat through STEPS = ceil(VALUE_BITS / 2) steps
// of the two-bit-per-cycle shift-add-3 converter until the converted word is
// pushed; a new value is taken only once busy drops. The emitter sends one
// character per cycle while it emits a value (sign plus up to ten digits) from
// a 2-entry queue beside the converter. busy stays high while the queue is full.
// Reset is synchronous, active low, and returns both sides to idle with the
// queue empty. The receiver cannot stall: each result is shown for one cycle.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_strobe,
  output logic [6:0]                   out_char_code,
  output logic                         out_is_last
);

  localparam int Q_W = digits_for(VALUE_BITS) * 4 + 1;

  q_stat_t        q_stat;
  logic           push, pop;
  logic [Q_W-1:0] push_data, pop_data;

  sida_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_value  (in_value),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  sida_queue #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  sida_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

endmodule

/* verif/tb_signed_int_to_decimal_ascii.sv */
`timescale 1ns / 100ps
// Testbench for the signed integer to decimal ASCII text converter.
module tb_signed_int_to_decimal_ascii
  import sida_pkg::*;
;

  // One character beat of decimal text
  typedef struct {
    logic [6:0] code;
    logic       last;
  } text_beat_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_value;
  logic               out_strobe;
  logic [6:0]         out_char_code;
  logic               out_is_last;

  text_beat_t expected_text[$];
  int         max_gap;
  int         values_sent;
  int         negatives_sent;
  int         chars_checked;
  int         fail_count;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(32)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_char_code(out_char_code),
    .out_is_last  (out_is_last)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Expected text of one value: optional sign, then digits MSD first
  function automatic void predict_text(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [3:0]  digits[10];
    int          nd;
    text_beat_t  b;
    // magnitude kept unsigned so the most negative value fits
    mag = v[31] ? (32'd0 - $unsigned(v)) : $unsigned(v);
    nd = 0;
    if (mag == 32'd0) begin
      b.code = CHAR_ZERO;
      b.last = 1'b1;
      expected_text.push_back(b);
      return;
    end
    while (mag != 32'd0) begin
      digits[nd] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      nd++;
    end
    if (v[31]) begin
      b.code = CHAR_MINUS;
      b.last = 1'b0;
      expected_text.push_back(b);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      b.code = CHAR_ZERO + 7'(digits[i]);
      b.last = (i == 0);
      expected_text.push_back(b);
    end
  endfunction

  // Value with a random digit count (1..10) and random sign
  function automatic logic signed [31:0] random_by_length();
    int          ndig;
    longint      lo;
    longint      hi;
    logic [31:0] mag;
    ndig = $urandom_range(10, 1);
    lo = 1;
    repeat (ndig - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    mag = $urandom_range(32'(hi), 32'(lo));
    return ($urandom_range(1, 0) != 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // Drive one beat; start stays high across back-to-back beats
  task automatic send_value(input logic signed [31:0] v);
    int gap;
    gap = $urandom_range(max_gap, 0);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    predict_text(v);
    values_sent++;
    if (v < 0) negatives_sent++;
  endtask

  // Drop start and hold off until all pending text has come out
  task automatic drain_text();
    @(negedge clk);
    start <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  // Result checker: every strobed character against the oldest expectation
  always @(posedge clk) begin
    text_beat_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (expected_text.size() == 0) begin
        $error("unexpected beat: char_code=%0d is_last=%0b", out_char_code, out_is_last);
        fail_count++;
      end else begin
        want = expected_text.pop_front();
        chars_checked++;
        if (out_char_code !== want.code) begin
          $error("char_code mismatch: expected %0d, actual %0d", want.code, out_char_code);
          fail_count++;
        end
        if (out_is_last !== want.last) begin
          $error("is_last mismatch: expected %0b, actual %0b", want.last, out_is_last);
          fail_count++;
        end
      end
    end else if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      $error("out_strobe unknown after reset");
      fail_count++;
    end
  end

  // Zero, single digits, decade edges and both ends of the range
  task automatic test_directed();
    logic signed [31:0] corner[20];
    corner = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
               32'sd100, -32'sd100, 32'sd12345, -32'sd67890, 32'sd999999999,
               32'sd1000000000, -32'sd1000000000, 32'sd2147483647, -32'sd2147483647,
               32'sh8000_0000, 32'sd1234567890, -32'sd1234567890};
    foreach (corner[i]) send_value(corner[i]);
  endtask

  // Random digit counts; one full drain in the middle
  task automatic test_random_lengths(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_text();
      send_value(random_by_length());
    end
  endtask

  // Raw 32-bit words: every input bit toggles
  task automatic test_full_range(input int n);
    repeat (n) send_value($signed($urandom));
  endtask

  // No sender gaps at all: a new value as soon as busy drops
  task automatic test_back_to_back(input int n);
    int saved_gap;
    saved_gap = max_gap;
    max_gap = 0;
    repeat (n) send_value(random_by_length());
    max_gap = saved_gap;
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_value       = '0;
    max_gap        = 12;
    values_sent    = 0;
    negatives_sent = 0;
    chars_checked  = 0;
    fail_count     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_lengths(220);
    test_back_to_back(40);
    test_full_range(200);

    drain_text();
    repeat (40) @(posedge clk);

    $display("run: %0d values converted (%0d negative), %0d characters checked",
             values_sent, negatives_sent, chars_checked);
    $display("run: zero, decade edges, both range extremes, gap-free and gapped input");
    if (fail_count == 0 && expected_text.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
